FILE: rtl/tdct_pkg.sv
package tdct_pkg;

  localparam int COLUMN_BITS_DEF = 32;
  localparam logic [7:0] TAB_RESET = 8'd8;
  localparam logic [7:0] TAB_DEFAULT = 8'd8;

  typedef enum logic [2:0] {
    ESC_NONE,
    ESC_SEEN,
    ESC_CSI,
    ESC_OSC,
    ESC_OSC_ESC
  } esc_mode_t;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } back_state_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        first_byte;
    logic [31:0] start_column;
    logic        end_of_text;
  } item_t;

  typedef struct packed {
    logic [20:0] lo;
    logic [20:0] hi;
  } cp_range_t;

  localparam int ZW_N = 180;
  localparam int WIDE_N = 65;

  localparam cp_range_t ZW_TAB [ZW_N] = '{
'{'h0300,'h036f},'{'h0483,'h0489},'{'h0591,'h05bd},'{'h05bf,'h05bf},'{'h05c1,'h05c2},
'{'h05c4,'h05c5},'{'h05c7,'h05c7},'{'h0610,'h061a},
'{'h064b,'h065f},'{'h0670,'h0670},'{'h06d6,'h06dc},'{'h06df,'h06e4},'{'h06e7,'h06e8},
'{'h06ea,'h06ed},'{'h0711,'h0711},'{'h0730,'h074a},
'{'h07a6,'h07b0},'{'h07eb,'h07f3},'{'h0816,'h0819},'{'h081b,'h0823},'{'h0825,'h0827},
'{'h0829,'h082d},'{'h0859,'h085b},'{'h08d3,'h08e1},
'{'h08e3,'h0903},'{'h093a,'h093c},'{'h093e,'h094f},'{'h0951,'h0957},'{'h0962,'h0963},
'{'h0981,'h0983},'{'h09bc,'h09bc},'{'h09be,'h09c4},
'{'h09c7,'h09c8},'{'h09cb,'h09cd},'{'h0a01,'h0a03},'{'h0a3c,'h0a3c},'{'h0a3e,'h0a42},
'{'h0a47,'h0a48},'{'h0a4b,'h0a4d},'{'h0abc,'h0abc},
'{'h0abe,'h0ac5},'{'h0ac7,'h0ac9},'{'h0acb,'h0acd},'{'h0b01,'h0b03},'{'h0b3c,'h0b3c},
'{'h0b3e,'h0b44},'{'h0b47,'h0b48},'{'h0b4b,'h0b4d},
'{'h0b56,'h0b57},'{'h0bbe,'h0bc2},'{'h0bc6,'h0bc8},'{'h0bca,'h0bcd},'{'h0c00,'h0c04},
'{'h0c3e,'h0c44},'{'h0c46,'h0c48},'{'h0c4a,'h0c4d},
'{'h0c55,'h0c56},'{'h0c81,'h0c83},'{'h0cbc,'h0cbc},'{'h0cbe,'h0cc4},'{'h0cc6,'h0cc8},
'{'h0cca,'h0ccd},'{'h0d00,'h0d03},'{'h0d3b,'h0d3c},
'{'h0d3e,'h0d44},'{'h0d46,'h0d48},'{'h0d4a,'h0d4d},'{'h0d57,'h0d57},'{'h0e31,'h0e31},
'{'h0e34,'h0e3a},'{'h0e47,'h0e4e},'{'h0eb1,'h0eb1},
'{'h0eb4,'h0ebc},'{'h0ec8,'h0ecd},'{'h0f18,'h0f19},'{'h0f35,'h0f35},'{'h0f37,'h0f37},
'{'h0f39,'h0f39},'{'h0f71,'h0f84},'{'h0f86,'h0f87},
'{'h0f8d,'h0fbc},'{'h0fc6,'h0fc6},'{'h102b,'h103e},'{'h1056,'h1059},'{'h105e,'h1060},
'{'h1062,'h1064},'{'h1067,'h106d},'{'h1071,'h1074},
'{'h1082,'h108d},'{'h109a,'h109d},'{'h135d,'h135f},'{'h1712,'h1715},'{'h1732,'h1734},
'{'h1752,'h1753},'{'h1772,'h1773},'{'h17b4,'h17d3},
'{'h180b,'h180f},'{'h1885,'h1886},'{'h18a9,'h18a9},'{'h1920,'h192b},'{'h1930,'h193b},
'{'h1a17,'h1a1b},'{'h1a55,'h1a5e},'{'h1a60,'h1a7c},
'{'h1a7f,'h1a7f},'{'h1ab0,'h1ace},'{'h1b00,'h1b04},'{'h1b34,'h1b44},'{'h1b6b,'h1b73},
'{'h1b80,'h1b82},'{'h1ba1,'h1bad},'{'h1be6,'h1bf3},
'{'h1c24,'h1c37},'{'h1cd0,'h1cd2},'{'h1cd4,'h1ce8},'{'h1ced,'h1ced},'{'h1cf2,'h1cf4},
'{'h1cf7,'h1cf9},'{'h1dc0,'h1dff},'{'h200b,'h200f},
'{'h202a,'h202e},'{'h2060,'h2064},'{'h2066,'h206f},'{'hfe00,'hfe0f},'{'hfe20,'hfe2f},
'{'hfff9,'hfffb},'{'h101fd,'h101fd},'{'h102e0,'h102e0},
'{'h10a01,'h10a03},'{'h10a05,'h10a06},'{'h10a0c,'h10a0f},'{'h10a38,'h10a3a},
'{'h10a3f,'h10a3f},'{'h10ae5,'h10ae6},'{'h10d24,'h10d27},'{'h10eab,'h10eac},
'{'h10f46,'h10f50},'{'h11000,'h11002},'{'h11038,'h11046},'{'h11070,'h11082},
'{'h110b0,'h110ba},'{'h11100,'h11102},'{'h11127,'h11134},'{'h11145,'h11146},
'{'h11173,'h11173},'{'h11180,'h11182},'{'h111b3,'h111c0},'{'h111c9,'h111cc},
'{'h1122c,'h11237},'{'h112df,'h112ea},'{'h11300,'h11303},'{'h1133b,'h1133c},
'{'h1133e,'h11344},'{'h11347,'h11348},'{'h1134b,'h1134d},'{'h11357,'h11357},
'{'h11435,'h11446},'{'h1145e,'h1145e},'{'h11630,'h11640},'{'h116ab,'h116b7},
'{'h16af0,'h16af4},'{'h16b30,'h16b36},'{'h1bc9d,'h1bc9e},'{'h1d165,'h1d169},
'{'h1d16d,'h1d172},'{'h1d17b,'h1d182},'{'h1d185,'h1d18b},'{'h1d1aa,'h1d1ad},
'{'h1da00,'h1da36},'{'h1da3b,'h1da6c},'{'h1da75,'h1da75},'{'h1da84,'h1da84},
'{'h1da9b,'h1da9f},'{'h1daa1,'h1daaf},'{'h1e000,'h1e02a},'{'h1e130,'h1e136},
'{'h1e2ae,'h1e2ef},'{'h1e8d0,'h1e8d6},'{'h1e944,'h1e94a},'{'he0100,'he01ef}
  };

  localparam cp_range_t WIDE_TAB [WIDE_N] = '{
'{'h1100,'h115f},'{'h231a,'h231b},'{'h2329,'h232a},'{'h23e9,'h23ec},'{'h23f0,'h23f0},
'{'h23f3,'h23f3},'{'h25fd,'h25fe},'{'h2614,'h2615},
'{'h2648,'h2653},'{'h267f,'h267f},'{'h2693,'h2693},'{'h26a1,'h26a1},'{'h26aa,'h26ab},
'{'h26bd,'h26be},'{'h26c4,'h26c5},'{'h26ce,'h26ce},
'{'h26d4,'h26d4},'{'h26ea,'h26ea},'{'h26f2,'h26f3},'{'h26f5,'h26f5},'{'h26fa,'h26fa},
'{'h26fd,'h26fd},'{'h2705,'h2705},'{'h270a,'h270b},
'{'h2728,'h2728},'{'h274c,'h274c},'{'h274e,'h274e},'{'h2753,'h2755},'{'h2757,'h2757},
'{'h2795,'h2797},'{'h27b0,'h27b0},'{'h27bf,'h27bf},
'{'h2b1b,'h2b1c},'{'h2b50,'h2b50},'{'h2b55,'h2b55},'{'h2e80,'h303e},'{'h3040,'ha4cf},
'{'hac00,'hd7a3},'{'hf900,'hfaff},'{'hfe10,'hfe19},
'{'hfe30,'hfe6f},'{'hff00,'hff60},'{'hffe0,'hffe6},'{'h16fe0,'h16fe4},'{'h17000,'h187f7},
'{'h18800,'h18cd5},'{'h1f004,'h1f004},'{'h1f0cf,'h1f0cf},
'{'h1f18e,'h1f18e},'{'h1f191,'h1f19a},'{'h1f200,'h1f251},'{'h1f300,'h1f64f},
'{'h1f680,'h1f6ff},'{'h1f700,'h1f773},'{'h1f780,'h1f7d8},'{'h1f7e0,'h1f7eb},
'{'h1f800,'h1f80b},'{'h1f810,'h1f847},'{'h1f850,'h1f859},'{'h1f860,'h1f887},
'{'h1f890,'h1f8ad},'{'h1f900,'h1f9ff},'{'h1fa70,'h1faff},'{'h20000,'h2fffd},
'{'h30000,'h3fffd}
  };

  function automatic logic is_zw(logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < ZW_N; i++) begin
      if (cp >= ZW_TAB[i].lo && cp <= ZW_TAB[i].hi) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_wide(logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < WIDE_N; i++) begin
      if (cp >= WIDE_TAB[i].lo && cp <= WIDE_TAB[i].hi) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] len;
    priority if ((b & 8'h80) == 8'h00) len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  function automatic logic cont_ok(logic [7:0] lead, logic [1:0] pos, logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (pos == 2'd1) begin
      priority if (lead == 8'hE0) lo = 8'hA0;
      else if (lead == 8'hED) hi = 8'h9F;
      else if (lead == 8'hF0) lo = 8'h90;
      else if (lead == 8'hF4) hi = 8'h8F;
      else hi = 8'hBF;
    end
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

FILE: rtl/tdct_queue.sv
module tdct_queue
  import tdct_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t      slot_r [2];
  logic       rd_r;
  logic       rd_nxt;
  logic       wr_r;
  logic       wr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_r];

  always_comb begin
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/tdct_back.sv
module tdct_back
  import tdct_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_column,
  output logic        out_tail_incomplete,
  output logic        out_text_done
);

  localparam int CW = COLUMN_BITS;
  localparam int DCW = $clog2(COLUMN_BITS);

  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] a, logic [8:0] n);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(n);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  back_state_t state_r;
  back_state_t state_nxt;
  logic [7:0]  tab_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  esc_mode_t   esc_r;
  esc_mode_t   esc_nxt;
  logic [1:0]  lw_r;
  logic [1:0]  lw_nxt;
  logic [CW-1:0] div_sh_r;
  logic [CW-1:0] div_sh_nxt;
  logic [7:0]  rem_r;
  logic [7:0]  rem_nxt;
  logic [DCW-1:0] dcnt_r;
  logic [DCW-1:0] dcnt_nxt;
  logic        pend_tail_r;
  logic        pend_tail_nxt;
  logic        pend_done_r;
  logic        pend_done_nxt;
  logic        ov_r;
  logic        ov_nxt;
  logic [CW-1:0] ocol_r;
  logic [CW-1:0] ocol_nxt;
  logic        otail_r;
  logic        otail_nxt;
  logic        odone_r;
  logic        odone_nxt;

  logic [7:0]  tab_eff;
  logic [CW-1:0] c;
  logic [1:0]  k;
  esc_mode_t   e;
  logic [1:0]  w;
  logic        tab_hit;
  logic        start_seg;
  logic        app_en;
  logic [20:0] cp;
  logic [2:0]  need;
  logic [2:0]  blen;
  logic        inc;
  logic [8:0]  rem_sh;
  logic [7:0]  b;

  assign tab_eff = (tab_r == 8'd0) ? TAB_DEFAULT : tab_r;
  assign out_valid = ov_r;
  assign out_column = 32'(ocol_r);
  assign out_tail_incomplete = otail_r;
  assign out_text_done = odone_r;

  always_comb begin
    b = item.text_byte;
    held_nxt = held_r;
    c = col_r;
    k = cnt_r;
    e = esc_r;
    w = lw_r;
    tab_hit = 1'b0;
    start_seg = 1'b0;
    app_en = 1'b0;
    cp = 21'(b);
    need = lead_len(held_r[0]);
    blen = lead_len(b);
    inc = 1'b0;
    if (item.first_byte) begin
      c = ((item.start_column >> CW) != 32'd0) ? {CW{1'b1}} : CW'(item.start_column);
      k = 2'd0;
      e = ESC_NONE;
      w = 2'd0;
    end
    unique case (e)
      ESC_SEEN: e = (b == 8'h5B) ? ESC_CSI : (b == 8'h5D) ? ESC_OSC : ESC_NONE;
      ESC_CSI: if (b >= 8'h40 && b <= 8'h7E) e = ESC_NONE;
      ESC_OSC: begin
        if (b == 8'h07) e = ESC_NONE;
        else if (b == 8'h1B) e = ESC_OSC_ESC;
      end
      ESC_OSC_ESC: begin
        if (b == 8'h5C || b == 8'h07) e = ESC_NONE;
        else if (b != 8'h1B) e = ESC_OSC;
      end
      default: begin
        e = ESC_NONE;
        if (k != 2'd0) begin
          if (cont_ok(held_r[0], k, b)) begin
            if ({1'b0, k} + 3'd1 >= need) begin
              app_en = 1'b1;
              priority if (need == 3'd2) cp = {10'd0, held_r[0][4:0], b[5:0]};
              else if (need == 3'd3) cp = {5'd0, held_r[0][3:0], held_r[1][5:0], b[5:0]};
              else cp = {held_r[0][2:0], held_r[1][5:0], held_r[2][5:0], b[5:0]};
              k = 2'd0;
            end else begin
              held_nxt[k] = b;
              k = k + 2'd1;
            end
          end else begin
            c = sat_add(c, {7'd0, k});
            k = 2'd0;
            start_seg = 1'b1;
          end
        end else begin
          start_seg = 1'b1;
        end
        if (start_seg) begin
          if (blen > 3'd1 && (blen - 3'd1) > {1'b0, w}) w = 2'(blen - 3'd1);
          priority if (b == 8'h1B) e = ESC_SEEN;
          else if (b < 8'h80) app_en = 1'b1;
          else if (b >= 8'hC2 && b <= 8'hF4) begin
            held_nxt[0] = b;
            k = 2'd1;
          end else c = sat_add(c, 9'd1);
        end
        if (app_en) begin
          priority if (cp == 21'h08) begin
            if (c != '0) c = c - CW'(1);
          end else if (cp == 21'h0D) c = '0;
          else if (cp == 21'h09) tab_hit = 1'b1;
          else if (cp < 21'h20 || (cp >= 21'h7f && cp < 21'ha0)) c = c;
          else if (is_zw(cp)) c = c;
          else if (is_wide(cp)) c = sat_add(c, 9'd2);
          else c = sat_add(c, 9'd1);
        end
      end
    endcase
    if (item.end_of_text) begin
      inc = (e != ESC_NONE) || (w != 2'd0);
      c = sat_add(c, {7'd0, k});
      k = 2'd0;
      e = ESC_NONE;
      w = 2'd0;
    end else if (w != 2'd0) begin
      w = w - 2'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    cnt_nxt = cnt_r;
    esc_nxt = esc_r;
    lw_nxt = lw_r;
    div_sh_nxt = div_sh_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    pend_tail_nxt = pend_tail_r;
    pend_done_nxt = pend_done_r;
    ov_nxt = ov_r && !out_ready;
    ocol_nxt = ocol_r;
    otail_nxt = otail_r;
    odone_nxt = odone_r;
    item_pop = 1'b0;
    rem_sh = {rem_r, div_sh_r[CW-1]};
    unique case (state_r)
      ST_RUN: begin
        if (item_valid && (!ov_r || out_ready)) begin
          item_pop = 1'b1;
          cnt_nxt = k;
          esc_nxt = e;
          lw_nxt = w;
          if (tab_hit) begin
            state_nxt = ST_DIV;
            col_nxt = c;
            div_sh_nxt = c;
            rem_nxt = 8'd0;
            dcnt_nxt = DCW'(CW - 1);
            pend_tail_nxt = inc;
            pend_done_nxt = item.end_of_text;
          end else begin
            col_nxt = c;
            ov_nxt = 1'b1;
            ocol_nxt = c;
            otail_nxt = item.end_of_text && inc;
            odone_nxt = item.end_of_text;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = (rem_sh >= {1'b0, tab_eff}) ? 8'(rem_sh - {1'b0, tab_eff}) : rem_sh[7:0];
        div_sh_nxt = {div_sh_r[CW-2:0], 1'b0};
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == '0) begin
          state_nxt = ST_RUN;
          col_nxt = sat_add(col_r, {1'b0, tab_eff} - {1'b0, rem_nxt});
          ov_nxt = 1'b1;
          ocol_nxt = col_nxt;
          otail_nxt = pend_done_r && pend_tail_r;
          odone_nxt = pend_done_r;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      tab_r <= TAB_RESET;
      col_r <= '0;
      cnt_r <= 2'd0;
      esc_r <= ESC_NONE;
      lw_r <= 2'd0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) tab_r <= cfg_wr_data;
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
      esc_r <= esc_nxt;
      lw_r <= lw_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) held_r <= held_nxt;
    div_sh_r <= div_sh_nxt;
    rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    pend_tail_r <= pend_tail_nxt;
    pend_done_r <= pend_done_nxt;
    ocol_r <= ocol_nxt;
    otail_r <= otail_nxt;
    odone_r <= odone_nxt;
  end

endmodule

FILE: rtl/terminal_display_column_tracker.sv
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_text_byte, in_first_byte, in_start_column,
//                     in_end_of_text
// out      output     out_valid, out_ready, out_column, out_tail_incomplete, out_text_done
// cfg      input      cfg_wr_en, cfg_wr_data (tab width)
//
// Each request is resolved directly by the back end, except a tab, which waits for the tab stop
// remainder from a one bit per cycle divider.
// Reset is synchronous and active low; the tab width returns to eight.
// A two-entry queue takes requests while the back end waits for out_ready.
module terminal_display_column_tracker
  import tdct_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_first_byte,
  input  logic [31:0] in_start_column,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_column,
  output logic        out_tail_incomplete,
  output logic        out_text_done,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  item_t in_item;
  item_t head;
  logic  full;
  logic  not_empty;
  logic  pop;

  assign in_ready = !full;
  assign in_item = '{text_byte: in_text_byte, first_byte: in_first_byte,
                     start_column: in_start_column, end_of_text: in_end_of_text};

  tdct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !full),
    .push_item (in_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  tdct_back #(.COLUMN_BITS(COLUMN_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .item_valid          (not_empty),
    .item                (head),
    .item_pop            (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_column          (out_column),
    .out_tail_incomplete (out_tail_incomplete),
    .out_text_done       (out_text_done)
  );

endmodule
